/* hw/rtl/dvrt_pkg.sv */
// Shared types and codes for the distance-vector route table.
`default_nettype none

package dvrt_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ADVERT = 2'd1,
        ACT_DOWN   = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    // Packet travelling down the row of cells
    typedef struct packed {
        logic        vld;
        logic        apply;     // 0: gathering neighbour cost, 1: updating entries
        action_t     action;
        logic [2:0]  nb;
        logic        nb_ok;
        logic [2:0]  dest;
        logic [15:0] cost_in;
        logic [15:0] nb_cost;
        logic        lcl;
        logic [15:0] res_cost;
        logic [2:0]  res_hop;
        logic        res_valid;
        logic        changed;
    } dvrt_pkt_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  dest;
        logic [15:0] cost;
        logic [2:0]  hop;
        logic        valid;
        logic        lcl;
        logic        changed;
    } dvrt_res_t;

endpackage

`default_nettype wire

/* hw/rtl/dvrt_cell.sv */
// One route table entry with its slot of the packet chain.
`default_nettype none

module dvrt_cell
    import dvrt_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int COST_INF = 9999
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] self_node,
    input  wire dvrt_pkt_t  pkt_i,
    output dvrt_pkt_t       pkt_o
);

    localparam logic [15:0] INF = 16'(COST_INF);

    logic [15:0] cost_reg, cost_next;
    logic [2:0]  hop_reg, hop_next;
    logic        vld_reg, vld_next;
    dvrt_pkt_t   pkt_reg, pkt_next;

    logic        is_self;
    logic        at_dest;
    logic        at_nb;
    logic [16:0] sum;
    logic        chg;

    assign is_self = (int'(self_node) == IDX);
    assign at_dest = (int'(pkt_i.dest) == IDX);
    assign at_nb   = (int'(pkt_i.nb) == IDX);
    assign sum     = {1'b0, pkt_i.nb_cost} + {1'b0, pkt_i.cost_in};

    // Entry update and packet hand-on
    always_comb
    begin
        cost_next = cost_reg;
        hop_next  = hop_reg;
        vld_next  = vld_reg;
        pkt_next  = pkt_i;
        chg       = 1'b0;
        if (pkt_i.vld)
        begin
            if (!pkt_i.apply)
            begin
                // gather pass: pick up cost to the advertising neighbour
                if (at_nb)
                begin
                    pkt_next.nb_cost = is_self ? 16'd0 : cost_reg;
                end
            end
            else
            begin
                case (pkt_i.action)
                    ACT_LOAD:
                    begin
                        if (at_dest && !is_self)
                        begin
                            chg       = (cost_reg != pkt_i.cost_in) || (hop_reg != pkt_i.dest)
                                        || !vld_reg;
                            cost_next = pkt_i.cost_in;
                            hop_next  = pkt_i.dest;
                            vld_next  = 1'b1;
                        end
                    end
                    ACT_ADVERT:
                    begin
                        if (at_dest && !is_self && pkt_i.nb_ok)
                        begin
                            if (sum < {1'b0, cost_reg})
                            begin
                                cost_next = sum[15:0];
                                hop_next  = pkt_i.nb;
                                vld_next  = 1'b1;
                                chg       = 1'b1;
                            end
                            else if (sum == {1'b0, cost_reg})
                            begin
                                if (!vld_reg || (pkt_i.nb < hop_reg))
                                begin
                                    hop_next = pkt_i.nb;
                                    vld_next = 1'b1;
                                    chg      = 1'b1;
                                end
                            end
                        end
                    end
                    ACT_DOWN:
                    begin
                        if (!is_self && vld_reg && (hop_reg == pkt_i.nb))
                        begin
                            cost_next = INF;
                            hop_next  = 3'd0;
                            vld_next  = 1'b0;
                            chg       = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                pkt_next.changed = pkt_i.changed | chg;
                // report the destination entry as it stands after the step
                if (at_dest)
                begin
                    if (is_self)
                    begin
                        pkt_next.res_cost  = 16'd0;
                        pkt_next.res_hop   = 3'd0;
                        pkt_next.res_valid = 1'b0;
                    end
                    else
                    begin
                        pkt_next.res_cost  = cost_next;
                        pkt_next.res_hop   = vld_next ? hop_next : 3'd0;
                        pkt_next.res_valid = vld_next;
                    end
                end
            end
        end
    end

    // Entry and chain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg <= INF;
            hop_reg  <= 3'd0;
            vld_reg  <= 1'b0;
            pkt_reg  <= '0;
        end
        else
        begin
            cost_reg <= cost_next;
            hop_reg  <= hop_next;
            vld_reg  <= vld_next;
            pkt_reg  <= pkt_next;
        end
    end

    assign pkt_o = pkt_reg;

endmodule

`default_nettype wire

/* hw/rtl/distance_vector_route_table.sv */
// Distance-vector route table: row of entry cells with a sequencing controller.
// An item is registered on accept, passes down the cell row and is registered again at the
// result output; an advert makes two passes (one down the cell row to read the neighbour
// cost, one to update). The cell row holds one item at a time: a new item is accepted only
// after the last one has left it. Reset is asynchronous, active low: every cost reads as
// COST_INFINITY, no next hops, self_node 0, both channels empty.
`default_nettype none

module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int NODES         = 6,
    parameter int COST_INFINITY = 9999
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  self_node,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  neighbor,
    input  wire logic [2:0]  dest,
    input  wire logic [15:0] cost_in,
    // results
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       entry_dest,
    output logic [15:0]      entry_cost,
    output logic [2:0]       next_hop,
    output logic             route_valid,
    output logic             local_delivery,
    output logic             changed
);

    localparam logic [15:0] INF = 16'(COST_INFINITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] self_reg;
    dvrt_pkt_t  inj_reg, inj_next;
    dvrt_res_t  out_reg, out_next;
    dvrt_res_t  skid_reg, skid_next;
    logic       out_vld_reg, out_vld_next;
    logic       skid_vld_reg, skid_vld_next;
    dvrt_pkt_t  chain [NODES+1];
    dvrt_pkt_t  exit_pkt;
    dvrt_res_t  res;
    logic       in_acc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !skid_vld_reg;
    assign in_acc    = in_valid && in_ready;

    // Row of entry cells
    assign chain[0] = inj_reg;
    for (genvar k = 0; k < NODES; k++)
    begin : g_cell
        dvrt_cell #(
            .IDX      (k),
            .COST_INF (COST_INFINITY)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .self_node (self_reg),
            .pkt_i     (chain[k]),
            .pkt_o     (chain[k+1])
        );
    end
    assign exit_pkt = chain[NODES];

    always_comb
    begin
        res.dest    = exit_pkt.dest;
        res.cost    = exit_pkt.res_cost;
        res.hop     = exit_pkt.res_hop;
        res.valid   = exit_pkt.res_valid;
        res.lcl     = exit_pkt.lcl;
        res.changed = exit_pkt.changed;
    end

    // Sequencing: inject, second pass for adverts, collect result
    always_comb
    begin
        state_next    = state_reg;
        inj_next      = '0;
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    inj_next.vld       = 1'b1;
                    inj_next.apply     = (action_t'(action) != ACT_ADVERT);
                    inj_next.action    = action_t'(action);
                    inj_next.nb        = neighbor;
                    inj_next.nb_ok     = (int'(neighbor) < NODES);
                    inj_next.dest      = dest;
                    inj_next.cost_in   = cost_in;
                    inj_next.nb_cost   = 16'd0;
                    inj_next.lcl       = (action_t'(action) == ACT_LOOKUP) && (dest == self_reg);
                    inj_next.res_cost  = INF;
                    inj_next.res_hop   = 3'd0;
                    inj_next.res_valid = 1'b0;
                    inj_next.changed   = 1'b0;
                    state_next         = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (exit_pkt.vld && !exit_pkt.apply)
                begin
                    inj_next       = exit_pkt;
                    inj_next.apply = 1'b1;
                end
                else if (exit_pkt.vld)
                begin
                    if (!out_vld_next)
                    begin
                        out_next     = res;
                        out_vld_next = 1'b1;
                    end
                    else
                    begin
                        skid_next     = res;
                        skid_vld_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            self_reg     <= 3'd0;
            inj_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            inj_reg      <= inj_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
            if (cfg_valid)
            begin
                self_reg <= self_node;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_vld_reg;
    assign entry_dest     = out_reg.dest;
    assign entry_cost     = out_reg.cost;
    assign next_hop       = out_reg.hop;
    assign route_valid    = out_reg.valid;
    assign local_delivery = out_reg.lcl;
    assign changed        = out_reg.changed;

endmodule

`default_nettype wire

/* tb/sv/tb_distance_vector_route_table.sv */
// Self-checking testbench for the distance-vector route table, with its own route predictor.
`timescale 1ns / 1ps

module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int NODES     = 6;
    localparam int COST_INF  = 9999;
    localparam int LONG_HOLD = 300;
    localparam int SEGMENTS  = 9;
    localparam int SEG_ITEMS = 150;
    localparam int TAIL_WAIT = 40;
    localparam int DIR_N     = 23;

    // One directed beat; res is only used where typed is set
    typedef struct packed {
        action_t     act;
        logic [2:0]  nb;
        logic [2:0]  dst;
        logic [15:0] cost;
        logic        typed;
        dvrt_res_t   res;
    } stim_row_t;

    localparam dvrt_res_t NO_RES = '0;

    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        // fresh table: unknown route, then own node
        '{ACT_LOOKUP, 3'd0, 3'd3, 16'd0,     1'b1, '{3'd3, 16'd9999, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{ACT_LOOKUP, 3'd0, 3'd0, 16'd0,     1'b1, '{3'd0, 16'd0, 3'd0, 1'b0, 1'b1, 1'b0}},
        // direct links at the cost extremes
        '{ACT_LOAD,   3'd0, 3'd1, 16'd0,     1'b1, '{3'd1, 16'd0, 3'd1, 1'b1, 1'b0, 1'b1}},
        '{ACT_LOAD,   3'd0, 3'd2, 16'hFFFF,  1'b1, '{3'd2, 16'hFFFF, 3'd2, 1'b1, 1'b0, 1'b1}},
        // link to own node is ignored, link beyond the table too
        '{ACT_LOAD,   3'd0, 3'd0, 16'd5,     1'b1, '{3'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{ACT_LOAD,   3'd0, 3'd7, 16'd5,     1'b1, '{3'd7, 16'd9999, 3'd0, 1'b0, 1'b0, 1'b0}},
        // adverts: plain gain, 17-bit sum, own node adds nothing, tie to lower id
        '{ACT_ADVERT, 3'd1, 3'd3, 16'd10,    1'b0, NO_RES},
        '{ACT_ADVERT, 3'd2, 3'd3, 16'hFFFF,  1'b0, NO_RES},
        '{ACT_ADVERT, 3'd0, 3'd3, 16'd10,    1'b0, NO_RES},
        '{ACT_ADVERT, 3'd6, 3'd3, 16'd0,     1'b0, NO_RES},
        // tie at infinity installs a hop on an unrouted entry
        '{ACT_ADVERT, 3'd1, 3'd4, 16'd9999,  1'b0, NO_RES},
        '{ACT_ADVERT, 3'd1, 3'd0, 16'd0,     1'b0, NO_RES},
        '{ACT_ADVERT, 3'd3, 3'd5, 16'hFFFF,  1'b0, NO_RES},
        // neighbour down: real, out of range, own node as hop
        '{ACT_DOWN,   3'd1, 3'd4, 16'd0,     1'b0, NO_RES},
        '{ACT_DOWN,   3'd7, 3'd2, 16'd0,     1'b0, NO_RES},
        '{ACT_DOWN,   3'd0, 3'd3, 16'd0,     1'b0, NO_RES},
        '{ACT_LOOKUP, 3'd0, 3'd6, 16'd0,     1'b1, '{3'd6, 16'd9999, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{ACT_LOOKUP, 3'd5, 3'd2, 16'hFFFF,  1'b0, NO_RES},
        // reloading an identical link reports no change
        '{ACT_LOAD,   3'd0, 3'd5, 16'd9999,  1'b0, NO_RES},
        '{ACT_LOAD,   3'd0, 3'd5, 16'd9999,  1'b0, NO_RES},
        '{ACT_LOOKUP, 3'd7, 3'd7, 16'hFFFF,  1'b0, NO_RES},
        '{ACT_ADVERT, 3'd5, 3'd2, 16'd0,     1'b0, NO_RES},
        '{ACT_DOWN,   3'd5, 3'd5, 16'd0,     1'b0, NO_RES}
    };

    localparam logic [2:0] SELF_PLAN [SEGMENTS] = '{3'd0, 3'd5, 3'd2, 3'd7, 3'd0,
                                                     3'd3, 3'd4, 3'd1, 3'd5};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  self_node;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [2:0]  neighbor;
    logic [2:0]  dest;
    logic [15:0] cost_in;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  entry_dest;
    logic [15:0] entry_cost;
    logic [2:0]  next_hop;
    logic        route_valid;
    logic        local_delivery;
    logic        changed;

    // Predictor copy of the table and the node register
    logic [15:0] rt_cost [NODES];
    logic [2:0]  rt_hop  [NODES];
    logic        rt_ok   [NODES];
    logic [2:0]  my_node;

    dvrt_res_t   route_expect_q [$];
    int          fault_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;

    distance_vector_route_table #(
        .NODES         (NODES),
        .COST_INFINITY (COST_INF)
    ) dut (.*);

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cost of a node as the table reads it
    function automatic logic [15:0] node_cost(input logic [2:0] n);
        if (n >= NODES)
            return 16'(COST_INF);
        if (n == my_node)
            return 16'd0;
        return rt_cost[n];
    endfunction

    // Apply one beat to the predicted table and return the entry it reports
    function automatic dvrt_res_t route_step(input action_t act, input logic [2:0] nb,
                                             input logic [2:0] dst, input logic [15:0] cost);
        dvrt_res_t   r;
        logic [16:0] sum;
        logic        dst_ok;
        logic        chg;
        chg    = 1'b0;
        dst_ok = (dst < NODES) && (dst != my_node);
        case (act)
            ACT_LOAD:
            begin
                if (dst_ok)
                begin
                    if (rt_cost[dst] != cost || rt_hop[dst] != dst || !rt_ok[dst])
                        chg = 1'b1;
                    rt_cost[dst] = cost;
                    rt_hop[dst]  = dst;
                    rt_ok[dst]   = 1'b1;
                end
            end
            ACT_ADVERT:
            begin
                if (dst_ok && nb < NODES)
                begin
                    sum = {1'b0, node_cost(nb)} + {1'b0, cost};
                    if (sum < {1'b0, rt_cost[dst]})
                    begin
                        rt_cost[dst] = sum[15:0];
                        rt_hop[dst]  = nb;
                        rt_ok[dst]   = 1'b1;
                        chg          = 1'b1;
                    end
                    else if (sum == {1'b0, rt_cost[dst]} && (!rt_ok[dst] || nb < rt_hop[dst]))
                    begin
                        rt_hop[dst] = nb;
                        rt_ok[dst]  = 1'b1;
                        chg         = 1'b1;
                    end
                end
            end
            ACT_DOWN:
            begin
                for (int i = 0; i < NODES; i++)
                begin
                    if (i != my_node && rt_ok[i] && rt_hop[i] == nb)
                    begin
                        rt_cost[i] = 16'(COST_INF);
                        rt_hop[i]  = 3'd0;
                        rt_ok[i]   = 1'b0;
                        chg        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.dest = dst;
        if (dst_ok)
        begin
            r.cost  = rt_cost[dst];
            r.hop   = rt_ok[dst] ? rt_hop[dst] : 3'd0;
            r.valid = rt_ok[dst];
        end
        else
        begin
            r.cost  = node_cost(dst);
            r.hop   = 3'd0;
            r.valid = 1'b0;
        end
        r.lcl     = (act == ACT_LOOKUP) && (dst == my_node);
        r.changed = chg;
        return r;
    endfunction

    // Offer one beat after an optional gap, then log what it should report
    task automatic push_item(input action_t act, input logic [2:0] nb, input logic [2:0] dst,
                             input logic [15:0] cost, input logic typed,
                             input dvrt_res_t typed_res);
        int        gap;
        dvrt_res_t predicted;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        neighbor <= nb;
        dest     <= dst;
        cost_in  <= cost;
        do @(posedge clk); while (!in_ready);
        predicted = route_step(act, nb, dst, cost);
        route_expect_q.push_back(typed ? typed_res : predicted);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (route_expect_q.size() != 0);
    endtask

    task automatic write_self(input logic [2:0] v);
        cfg_valid <= 1'b1;
        self_node <= v;
        do @(posedge clk); while (!cfg_ready);
        my_node = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [2:0] pick_node();
        if ($urandom_range(99) < 6)
            return 3'($urandom_range(6, 7));
        return 3'($urandom_range(5));
    endfunction

    function automatic logic [15:0] pick_cost();
        int w;
        w = $urandom_range(99);
        if (w < 45)
            return 16'($urandom_range(30));
        if (w < 55)
            return 16'(COST_INF);
        if (w < 60)
            return 16'hFFFF;
        if (w < 65)
            return 16'd0;
        return 16'($urandom);
    endfunction

    // Receiver: random back-pressure, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        dvrt_res_t got;
        dvrt_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{entry_dest, entry_cost, next_hop, route_valid, local_delivery, changed};
            if (route_expect_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result beat: dest %0d cost %0d hop %0d", got.dest,
                             got.cost, got.hop);
            end
            else
            begin
                want = route_expect_q.pop_front();
                if (got.dest != want.dest || got.cost != want.cost || got.hop != want.hop ||
                    got.valid != want.valid || got.lcl != want.lcl ||
                    got.changed != want.changed)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $write("mismatch: got dest %0d cost %0d hop %0d valid %0b lcl %0b ",
                               got.dest, got.cost, got.hop, got.valid, got.lcl);
                        $write("chg %0b; want dest %0d cost %0d hop %0d ", got.changed,
                               want.dest, want.cost, want.hop);
                        $display("valid %0b lcl %0b chg %0b", want.valid, want.lcl,
                                 want.changed);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        action_t act;
        int      w;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        self_node   = 3'd0;
        in_valid    = 1'b0;
        action      = ACT_LOAD;
        neighbor    = 3'd0;
        dest        = 3'd0;
        cost_in     = 16'd0;
        out_ready   = 1'b0;
        fault_count = 0;
        tx_idle_pct = 11;
        rx_idle_pct = 45;
        hold_reqs   = 0;
        hold_seen   = 0;
        hold_left   = 0;
        my_node     = 3'd0;
        for (int i = 0; i < NODES; i++)
        begin
            rt_cost[i] = 16'(COST_INF);
            rt_hop[i]  = 3'd0;
            rt_ok[i]   = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats, node register still at its reset value
        for (int r = 0; r < DIR_N; r++)
            push_item(DIR_ROWS[r].act, DIR_ROWS[r].nb, DIR_ROWS[r].dst, DIR_ROWS[r].cost,
                      DIR_ROWS[r].typed, DIR_ROWS[r].res);

        // random segments, each under its own node setting and idling mode
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            write_self(SELF_PLAN[seg]);
            if (seg < 3)
            begin
                tx_idle_pct =  11;
                rx_idle_pct <= 45;
            end
            else if (seg < 6)
            begin
                tx_idle_pct =  45;
                rx_idle_pct <= 11;
            end
            else
            begin
                tx_idle_pct =  0;
                rx_idle_pct <= 0;
            end
            // long receiver hold-off so the block backs up into the input
            if (seg == 1 || seg == 7)
                hold_reqs <= hold_reqs + 1;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                w = $urandom_range(99);
                if (w < 20)
                    act = ACT_LOAD;
                else if (w < 65)
                    act = ACT_ADVERT;
                else if (w < 75)
                    act = ACT_DOWN;
                else
                    act = ACT_LOOKUP;
                push_item(act, pick_node(), pick_node(), pick_cost(), 1'b0, NO_RES);
            end
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge clk);
        if (fault_count == 0 && route_expect_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
